/* rtl/bss_pkg.sv */
// Shared types and constants for the bounded sequence store.
`default_nettype none

package bss_pkg;

    localparam int Depth = 64;
    localparam int WordW = 32;
    localparam int IdxW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int ReqW  = 3;

    typedef enum logic [ReqW-1:0] {
        REQ_PUSH_HEAD = 3'd0,
        REQ_POP_HEAD  = 3'd1,
        REQ_PUSH_TAIL = 3'd2,
        REQ_POP_TAIL  = 3'd3,
        REQ_FIND      = 3'd4,
        REQ_DELETE    = 3'd5,
        REQ_READ_AT   = 3'd6,
        REQ_CLEAR     = 3'd7
    } t_req_type;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_WRITE,
        CELL_ROTATE,
        CELL_DROP
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_cell_op               op;
        logic [IdxW-1:0]        sel;
        logic [WordW-1:0]       data;
    } t_cell_cmd;

    typedef struct packed {
        t_req_type              kind;
        logic [WordW-1:0]       data;
        logic [IdxW-1:0]        pos;
    } t_request;

    typedef struct packed {
        logic                   ok;
        logic [WordW-1:0]       data;
        logic [IdxW-1:0]        pos;
    } t_result;

endpackage

`default_nettype wire

/* rtl/bss_req_if.sv */
// Request channel interface of the bounded sequence store.
`default_nettype none

interface bss_req_if;
    logic                              valid;
    logic                              ready;
    logic [bss_pkg::ReqW-1:0]          req_type;
    logic signed [bss_pkg::WordW-1:0]  data_in;
    logic [bss_pkg::IdxW-1:0]          position_in;

    modport source (output valid, req_type, data_in, position_in, input ready);
    modport sink   (input valid, req_type, data_in, position_in, output ready);
endinterface

`default_nettype wire

/* rtl/bss_rsp_if.sv */
// Response channel interface of the bounded sequence store.
`default_nettype none

interface bss_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [bss_pkg::WordW-1:0]  data_out;
    logic [bss_pkg::IdxW-1:0]          position_out;

    modport source (output valid, ok, data_out, position_out, input ready);
    modport sink   (input valid, ok, data_out, position_out, output ready);
endinterface

`default_nettype wire

/* rtl/bss_cell.sv */
// One storage cell of the sequence chain; moves data to or from its neighbors.
`default_nettype none

module bss_cell (
    input  wire logic                       i_clk,
    input  wire bss_pkg::t_cell_cmd         i_cmd,
    input  wire logic [bss_pkg::IdxW-1:0]   i_index,
    input  wire logic [bss_pkg::WordW-1:0]  i_left,
    input  wire logic [bss_pkg::WordW-1:0]  i_right,
    input  wire logic [bss_pkg::WordW-1:0]  i_head,
    output logic [bss_pkg::WordW-1:0]       o_data
);

    logic [bss_pkg::WordW-1:0] r_data;
    logic [bss_pkg::WordW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            bss_pkg::CELL_SHR: begin
                n_data = i_left;
            end
            bss_pkg::CELL_SHL: begin
                n_data = i_right;
            end
            bss_pkg::CELL_WRITE: begin
                if (i_index == i_cmd.sel) n_data = i_cmd.data;
            end
            bss_pkg::CELL_ROTATE: begin
                if (i_index < i_cmd.sel) n_data = i_right;
                else if (i_index == i_cmd.sel) n_data = i_head;
            end
            bss_pkg::CELL_DROP: begin
                if (i_index < i_cmd.sel) n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/bss_ctrl.sv */
// Request sequencer: occupancy, scan walk over the chain and result staging.
`default_nettype none

module bss_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire bss_pkg::t_request          i_req,
    input  wire logic [bss_pkg::WordW-1:0]  i_head,
    output bss_pkg::t_cell_cmd              o_cmd,
    output logic                            o_res_valid,
    input  wire logic                       i_res_take,
    output bss_pkg::t_result                o_res
);

    bss_pkg::t_state                r_state, n_state;
    logic [bss_pkg::CntW-1:0]       r_occ, n_occ;
    logic [bss_pkg::CntW-1:0]       r_left, n_left;
    logic [bss_pkg::IdxW-1:0]       r_step, n_step;
    logic                           r_found, n_found;
    bss_pkg::t_request              r_req, n_req;
    bss_pkg::t_result               r_res, n_res;
    logic                           r_res_valid, n_res_valid;
    logic [bss_pkg::CntW-1:0]       w_occ_m1;
    logic                           w_accept;
    logic                           w_match;

    assign o_req_ready = (r_state == bss_pkg::ST_IDLE) && !r_res_valid;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_occ_m1    = r_occ - 1'b1;
    assign w_match     = (i_head == r_req.data) && !r_found;

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_left      = r_left;
        n_step      = r_step;
        n_found     = r_found;
        n_req       = r_req;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_take;
        o_cmd.op    = bss_pkg::CELL_HOLD;
        o_cmd.sel   = '0;
        o_cmd.data  = i_req.data;

        case (r_state)
            bss_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res       = '0;
                    n_res_valid = 1'b1;
                    n_req       = i_req;
                    n_left      = r_occ;
                    n_step      = '0;
                    n_found     = 1'b0;
                    case (i_req.kind)
                        bss_pkg::REQ_PUSH_HEAD: begin
                            if (r_occ < bss_pkg::CntW'(bss_pkg::Depth)) begin
                                o_cmd.op = bss_pkg::CELL_SHR;
                                n_occ    = r_occ + 1'b1;
                                n_res.ok = 1'b1;
                            end
                        end
                        bss_pkg::REQ_POP_HEAD: begin
                            if (r_occ != '0) begin
                                o_cmd.op   = bss_pkg::CELL_SHL;
                                n_occ      = w_occ_m1;
                                n_res.ok   = 1'b1;
                                n_res.data = i_head;
                            end
                        end
                        bss_pkg::REQ_PUSH_TAIL: begin
                            if (r_occ < bss_pkg::CntW'(bss_pkg::Depth)) begin
                                o_cmd.op  = bss_pkg::CELL_WRITE;
                                o_cmd.sel = r_occ[bss_pkg::IdxW-1:0];
                                n_occ     = r_occ + 1'b1;
                                n_res.ok  = 1'b1;
                            end
                        end
                        bss_pkg::REQ_POP_TAIL, bss_pkg::REQ_FIND, bss_pkg::REQ_DELETE: begin
                            if (r_occ != '0) begin
                                n_state     = bss_pkg::ST_SCAN;
                                n_res_valid = 1'b0;
                            end
                        end
                        bss_pkg::REQ_READ_AT: begin
                            if ({1'b0, i_req.pos} < r_occ) begin
                                n_state     = bss_pkg::ST_SCAN;
                                n_res_valid = 1'b0;
                            end
                        end
                        bss_pkg::REQ_CLEAR: begin
                            n_occ    = '0;
                            n_res.ok = 1'b1;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            bss_pkg::ST_SCAN: begin
                // cell 0 holds the entry at position r_step
                o_cmd.op  = bss_pkg::CELL_ROTATE;
                o_cmd.sel = w_occ_m1[bss_pkg::IdxW-1:0];
                case (r_req.kind)
                    bss_pkg::REQ_FIND: begin
                        if (w_match) begin
                            n_found   = 1'b1;
                            n_res.ok  = 1'b1;
                            n_res.pos = r_step;
                        end
                    end
                    bss_pkg::REQ_DELETE: begin
                        if (w_match) begin
                            o_cmd.op = bss_pkg::CELL_DROP;
                            n_occ    = w_occ_m1;
                            n_found  = 1'b1;
                            n_res.ok = 1'b1;
                        end
                    end
                    bss_pkg::REQ_READ_AT: begin
                        if (r_step == r_req.pos) begin
                            n_res.ok   = 1'b1;
                            n_res.data = i_head;
                        end
                    end
                    bss_pkg::REQ_POP_TAIL: begin
                        if (r_left == bss_pkg::CntW'(1)) begin
                            o_cmd.op   = bss_pkg::CELL_DROP;
                            n_occ      = w_occ_m1;
                            n_res.ok   = 1'b1;
                            n_res.data = i_head;
                        end
                    end
                    default: begin
                        n_found = r_found;
                    end
                endcase
                n_step = r_step + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == bss_pkg::CntW'(1)) begin
                    n_state     = bss_pkg::ST_IDLE;
                    n_res_valid = 1'b1;
                end
            end
            default: begin
                n_state = bss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bss_pkg::ST_IDLE;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_step  <= n_step;
        r_found <= n_found;
        r_req   <= n_req;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

/* rtl/bounded_sequence_store.sv */
// Bounded sequence store: ordered list of up to 64 signed words in a chain of cells.
//
// Requests enter on i_req (valid/ready); one response per request leaves on o_rsp.
// The entries live in a row of cells in list order, cell 0 holding the head.
// Push head, pop head and push tail move the whole row in a single step and clear
// only resets the occupancy; the result passes the staging register and then the
// output register, and the next request is taken once the staging slot is free.
// Pop tail, find, delete and read at rotate the row by one cell per cycle, once
// around the current occupancy N, with the head cell compared or captured on
// each step; delete drops one cell on a match and pop tail drops the last cell.
// Such a request has its result staged when the walk ends (N up to 64).
// Requests that miss at once (empty store, read position at or beyond
// occupancy) take the short path.
// Reset empties the store and drops any pending response; cell contents are
// not cleared and are never read before being written.
// A response that is not taken waits in the output register while one more
// result waits in the staging register; requests stall until the staging slot
// is free again.
`default_nettype none

module bounded_sequence_store (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bss_req_if.sink     i_req,
    bss_rsp_if.source   o_rsp
);

    bss_pkg::t_request          w_req;
    bss_pkg::t_cell_cmd         w_cmd;
    bss_pkg::t_result           w_res;
    logic                       w_res_valid;
    logic                       w_res_take;
    logic [bss_pkg::WordW-1:0]  w_cell [bss_pkg::Depth];

    logic                       r_out_valid;
    bss_pkg::t_result           r_out;

    assign w_req.kind = bss_pkg::t_req_type'(i_req.req_type);
    assign w_req.data = i_req.data_in;
    assign w_req.pos  = i_req.position_in;

    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (w_req),
        .i_head      (w_cell[0]),
        .o_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    for (genvar g = 0; g < bss_pkg::Depth; g++) begin : g_cell
        logic [bss_pkg::WordW-1:0] w_left;
        logic [bss_pkg::WordW-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cmd.data;
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end

        if (g == bss_pkg::Depth - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        bss_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (bss_pkg::IdxW'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    assign w_res_take = w_res_valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) r_out <= w_res;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out.ok;
    assign o_rsp.data_out     = r_out.data;
    assign o_rsp.position_out = r_out.pos;

endmodule

`default_nettype wire

/* rtl/bss_chk.sv */
// Port-level checker for the bounded sequence store, bound to the top level.
`default_nettype none

module bss_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic                       i_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic                       i_rsp_ok,
    input wire logic [bss_pkg::WordW-1:0]  i_rsp_data,
    input wire logic [bss_pkg::IdxW-1:0]   i_rsp_pos
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_ok) && $stable(i_rsp_data) && $stable(i_rsp_pos))
        else $error("response payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one is still staged");

endmodule

bind bounded_sequence_store bss_chk u_bss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_ok    (o_rsp.ok),
    .i_rsp_data  (o_rsp.data_out),
    .i_rsp_pos   (o_rsp.position_out)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for bounded_sequence_store against a queue-based list model.
`timescale 1ns / 100ps

module testbench;

    logic i_clk;
    logic i_rst_n;

    bss_req_if req_ch ();
    bss_rsp_if rsp_ch ();

    bounded_sequence_store uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic signed [bss_pkg::WordW-1:0] list_model[$];
    bss_pkg::t_result                 expected_rsp[$];
    int                               fail_count = 0;
    bit                               quiet = 1'b0;
    int                               hold_request = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [bss_pkg::WordW-1:0] pick_value();
        logic signed [bss_pkg::WordW-1:0] pool[8];
        pool = '{32'sh80000000, 32'sh7fffffff, 0, -1, 1, 5, 100, -77};
        if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // Applies one transaction to the list model and returns the response it must produce.
    function automatic bss_pkg::t_result apply_request(bss_pkg::t_req_type kind,
                                                       logic signed [bss_pkg::WordW-1:0] value,
                                                       logic [bss_pkg::IdxW-1:0] pos);
        bss_pkg::t_result r;
        int               hit;
        r   = '0;
        hit = -1;
        case (kind)
            bss_pkg::REQ_PUSH_HEAD: if (list_model.size() < bss_pkg::Depth) begin
                list_model.push_front(value);
                r.ok = 1'b1;
            end
            bss_pkg::REQ_POP_HEAD: if (list_model.size() > 0) begin
                r.data = list_model.pop_front();
                r.ok   = 1'b1;
            end
            bss_pkg::REQ_PUSH_TAIL: if (list_model.size() < bss_pkg::Depth) begin
                list_model.push_back(value);
                r.ok = 1'b1;
            end
            bss_pkg::REQ_POP_TAIL: if (list_model.size() > 0) begin
                r.data = list_model.pop_back();
                r.ok   = 1'b1;
            end
            bss_pkg::REQ_FIND, bss_pkg::REQ_DELETE: begin
                for (int i = 0; i < list_model.size(); i++) begin
                    if (list_model[i] == value) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    r.ok = 1'b1;
                    if (kind == bss_pkg::REQ_FIND) r.pos = bss_pkg::IdxW'(hit);
                    else list_model.delete(hit);
                end
            end
            bss_pkg::REQ_READ_AT: if (pos < list_model.size()) begin
                r.data = list_model[pos];
                r.ok   = 1'b1;
            end
            default: begin
                list_model.delete();
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic send_item(bss_pkg::t_req_type kind, logic signed [bss_pkg::WordW-1:0] value,
                             logic [bss_pkg::IdxW-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.data_in     <= value;
        req_ch.position_in <= pos;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_rsp.push_back(apply_request(kind, value, pos));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (bss_pkg::Depth + 8) @(posedge i_clk);
    endtask

    // Response side: random stalls, plus a long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        bss_pkg::t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: unexpected transaction ok=%0b data=%0d pos=%0d", $realtime,
                             rsp_ch.ok, $signed(rsp_ch.data_out), rsp_ch.position_out);
                fail_count++;
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.ok !== want.ok || rsp_ch.data_out !== want.data ||
                    rsp_ch.position_out !== want.pos) begin
                    if (fail_count < 10)
                        $display({"%0t: mismatch exp ok=%0b data=%0d pos=%0d, ",
                                  "got ok=%0b data=%0d pos=%0d"},
                                 $realtime, want.ok, $signed(want.data), want.pos, rsp_ch.ok,
                                 $signed(rsp_ch.data_out), rsp_ch.position_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        quiet = 1'b0;
        send_item(bss_pkg::REQ_POP_HEAD, 0, 0);
        send_item(bss_pkg::REQ_POP_TAIL, 0, 0);
        send_item(bss_pkg::REQ_FIND, 0, 0);
        send_item(bss_pkg::REQ_DELETE, 0, 0);
        send_item(bss_pkg::REQ_READ_AT, 0, 0);
        send_item(bss_pkg::REQ_PUSH_HEAD, 32'sh7fffffff, 0);
        send_item(bss_pkg::REQ_PUSH_HEAD, 32'sh80000000, 0);
        send_item(bss_pkg::REQ_PUSH_TAIL, 0, 0);
        send_item(bss_pkg::REQ_PUSH_TAIL, -1, 0);
        send_item(bss_pkg::REQ_PUSH_TAIL, 32'sh80000000, 0);
        send_item(bss_pkg::REQ_READ_AT, 0, 6'd4);
        send_item(bss_pkg::REQ_READ_AT, 0, 6'd5);
        send_item(bss_pkg::REQ_READ_AT, 32'shffffffff, 6'd63);
        send_item(bss_pkg::REQ_FIND, 32'sh80000000, 0);
        send_item(bss_pkg::REQ_FIND, -1, 0);
        send_item(bss_pkg::REQ_FIND, 12345, 0);
        send_item(bss_pkg::REQ_DELETE, 32'sh80000000, 0);
        send_item(bss_pkg::REQ_DELETE, 0, 0);
        send_item(bss_pkg::REQ_DELETE, 999, 0);
        send_item(bss_pkg::REQ_POP_TAIL, 0, 0);
        send_item(bss_pkg::REQ_POP_HEAD, 0, 0);
        send_item(bss_pkg::REQ_POP_HEAD, 0, 0);
        send_item(bss_pkg::REQ_POP_HEAD, 0, 0);
        send_item(bss_pkg::REQ_PUSH_TAIL, 42, 0);
        send_item(bss_pkg::REQ_CLEAR, 0, 0);
        send_item(bss_pkg::REQ_POP_TAIL, 0, 0);
        send_item(bss_pkg::REQ_CLEAR, 0, 0);
        wait_drained();
    endtask

    task automatic test_full_store();
        logic signed [bss_pkg::WordW-1:0] last_value;
        quiet = 1'b1;
        for (int i = 0; i < bss_pkg::Depth; i++) begin
            last_value = $urandom();
            send_item(bss_pkg::REQ_PUSH_TAIL, last_value, 0);
        end
        send_item(bss_pkg::REQ_PUSH_HEAD, 7, 0);
        send_item(bss_pkg::REQ_PUSH_TAIL, 7, 0);
        send_item(bss_pkg::REQ_READ_AT, 0, 6'd63);
        send_item(bss_pkg::REQ_FIND, last_value, 0);
        send_item(bss_pkg::REQ_DELETE, last_value, 0);
        quiet = 1'b0;
        while (list_model.size() > 0)
            send_item($urandom_range(0, 1) ? bss_pkg::REQ_POP_HEAD : bss_pkg::REQ_POP_TAIL,
                      0, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        quiet        = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 24; i++)
            send_item(i % 3 == 2 ? bss_pkg::REQ_FIND : bss_pkg::REQ_PUSH_HEAD,
                      pick_value(), 0);
        quiet = 1'b0;
        wait_drained();
    endtask

    function automatic bss_pkg::t_req_type pick_request(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 35) return bss_pkg::REQ_PUSH_HEAD;
            if (r < 70) return bss_pkg::REQ_PUSH_TAIL;
            if (r < 73) return bss_pkg::REQ_POP_HEAD;
            if (r < 76) return bss_pkg::REQ_POP_TAIL;
            if (r < 84) return bss_pkg::REQ_FIND;
            if (r < 88) return bss_pkg::REQ_DELETE;
            if (r < 99) return bss_pkg::REQ_READ_AT;
        end else begin
            if (r < 8)  return bss_pkg::REQ_PUSH_HEAD;
            if (r < 16) return bss_pkg::REQ_PUSH_TAIL;
            if (r < 40) return bss_pkg::REQ_POP_HEAD;
            if (r < 64) return bss_pkg::REQ_POP_TAIL;
            if (r < 74) return bss_pkg::REQ_FIND;
            if (r < 86) return bss_pkg::REQ_DELETE;
            if (r < 99) return bss_pkg::REQ_READ_AT;
        end
        return bss_pkg::REQ_CLEAR;
    endfunction

    task automatic test_random(int count);
        bss_pkg::t_req_type               kind;
        logic signed [bss_pkg::WordW-1:0] value;
        logic [bss_pkg::IdxW-1:0]         pos;
        for (int k = 0; k < count; k++) begin
            quiet = ((k / 60) % 4 == 3);
            kind  = pick_request((k / 100) % 2 == 0);
            value = pick_value();
            pos   = bss_pkg::IdxW'($urandom_range(0, bss_pkg::Depth - 1));
            if (list_model.size() > 0 && $urandom_range(0, 3) != 0) begin
                if (kind == bss_pkg::REQ_FIND || kind == bss_pkg::REQ_DELETE)
                    value = list_model[$urandom_range(0, list_model.size() - 1)];
                pos = bss_pkg::IdxW'($urandom_range(0, list_model.size() - 1));
            end
            send_item(kind, value, pos);
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= bss_pkg::REQ_PUSH_HEAD;
        req_ch.data_in     <= '0;
        req_ch.position_in <= '0;
        i_rst_n            <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_backpressure();
        test_random(220);
        if (fail_count == 0)
            $display("bounded_sequence_store regression: pass");
        else
            $display("bounded_sequence_store regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("bounded_sequence_store regression: fail");
        $finish;
    end

endmodule
